// File: design/swm_pkg.sv
// Shared constants and types for the sliding-window median block.
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int IDX_W      = $clog2(MAX_WINDOW);
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int CFG_W      = 7;
    localparam int SAMPLE_W   = 32;
    localparam int MEDIAN_W   = SAMPLE_W + 1;
    localparam int S_DATA_W   = ((SAMPLE_W + 7) / 8) * 8;
    localparam int M_DATA_W   = ((MEDIAN_W + 7) / 8) * 8;
    localparam int WIN_RESET  = 3;

    // Contents of one sorted slot
    typedef struct packed {
        logic                       vld;
        logic signed [SAMPLE_W-1:0] val;
        logic [IDX_W-1:0]           age;
    } cell_t;

    // Broadcast control seen by every slot
    typedef struct packed {
        logic                       step;
        logic                       purge;
        logic                       clear;
        logic signed [SAMPLE_W-1:0] sample;
        logic [IDX_W-1:0]           wm1;
    } cell_ctl_t;

endpackage

`default_nettype wire

// File: design/swm_cell.sv
// One slot of the sorted window: holds a sample and its age, shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module swm_cell (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  swm_pkg::cell_ctl_t   ctl,
    input  swm_pkg::cell_t       lower_i,
    input  swm_pkg::cell_t       upper_i,
    input  wire                  rem_in,
    input  wire                  gt_in,
    output swm_pkg::cell_t       slot_o,
    output logic                 rem_out,
    output logic                 gt_out,
    output logic                 multi_o
);

    swm_pkg::cell_t slot_reg;
    swm_pkg::cell_t slot_next;
    swm_pkg::cell_t lower_m;
    swm_pkg::cell_t own_m;
    swm_pkg::cell_t upper_m;
    swm_pkg::cell_t b_prev;
    swm_pkg::cell_t b_cur;
    logic           stale;
    logic           gt_cur;

    assign slot_o = slot_reg;

    // Slot is due to leave once its age reaches the window length minus one
    assign stale   = slot_reg.vld && (slot_reg.age >= ctl.wm1);
    assign rem_out = rem_in | stale;
    assign multi_o = stale & rem_in;

    // Drop validity of every slot when the sample restarts the window
    always_comb begin
        lower_m     = lower_i;
        own_m       = slot_reg;
        upper_m     = upper_i;
        lower_m.vld = lower_i.vld & ~ctl.clear;
        own_m.vld   = slot_reg.vld & ~ctl.clear;
        upper_m.vld = upper_i.vld & ~ctl.clear;
    end

    // Window after removing the first stale slot, at this and the lower position
    assign b_prev = rem_in  ? own_m   : lower_m;
    assign b_cur  = rem_out ? upper_m : own_m;

    assign gt_cur = !b_cur.vld || (b_cur.val > ctl.sample);
    assign gt_out = gt_cur;

    // Select kept, inserted or shifted-up entry
    always_comb begin
        slot_next = slot_reg;
        if (ctl.step) begin
            if (!gt_cur) begin
                slot_next     = b_cur;
                slot_next.age = b_cur.age + swm_pkg::IDX_W'(1);
            end else if (!gt_in) begin
                slot_next.vld = 1'b1;
                slot_next.val = ctl.sample;
                slot_next.age = '0;
            end else begin
                slot_next     = b_prev;
                slot_next.age = b_prev.age + swm_pkg::IDX_W'(1);
            end
        end else if (ctl.purge) begin
            slot_next = b_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg.vld <= 1'b0;
        end else begin
            slot_reg.vld <= slot_next.vld;
        end
        slot_reg.val <= slot_next.val;
        slot_reg.age <= slot_next.age;
    end

endmodule

`default_nettype wire

// File: design/swm_select.sv
// Picks the two middle slots of the window and sums them into twice the median.
`timescale 1ns / 1ps
`default_nettype none

module swm_select (
    input  swm_pkg::cell_t                    slots [swm_pkg::MAX_WINDOW],
    input  wire [swm_pkg::IDX_W-1:0]          lo_idx,
    input  wire [swm_pkg::IDX_W-1:0]          hi_idx,
    output logic signed [swm_pkg::MEDIAN_W-1:0] median_x2
);

    logic signed [swm_pkg::SAMPLE_W-1:0] lo_val;
    logic signed [swm_pkg::SAMPLE_W-1:0] hi_val;

    // AND-OR across slots, each slot matched at its own fixed position
    always_comb begin
        lo_val = '0;
        hi_val = '0;
        for (int i = 0; i < swm_pkg::MAX_WINDOW; i++) begin
            if (lo_idx == swm_pkg::IDX_W'(i)) begin
                lo_val = lo_val | slots[i].val;
            end
            if (hi_idx == swm_pkg::IDX_W'(i)) begin
                hi_val = hi_val | slots[i].val;
            end
        end
    end

    // Odd windows pick the same slot twice
    assign median_x2 = swm_pkg::MEDIAN_W'(lo_val) + swm_pkg::MEDIAN_W'(hi_val);

endmodule

`default_nettype wire

// File: design/sliding_window_median.sv
// Top level of the sliding-window median filter.
//
// Input stream: s_tdata carries one signed 32-bit sample per transfer,
// s_tuser carries the restart flag that empties the window before the sample.
// Output stream: m_tdata carries twice the median over the last window_size
// samples (33-bit signed), one transfer per sample once the window is full;
// samples that leave the window short of full give no transfer.
// cfg_wr_en / cfg_wr_data set window_size (0 acts as 1, above 64 acts as 64);
// write it only while the block is idle.
// The window is a row of 64 slots kept in ascending order; each sample is
// aged, evicted and inserted by all slots together in the cycle it is taken.
// A result waits in a pending register after its sample, then loads into the output register.
// Throughput: one sample per cycle while s_tready is high, as all slots update in the cycle a sample is taken.
// After a window shrink, s_tready stays low while the row squeezes the
// surplus entries out one at a time.
// Reset empties the window, sets window_size to 3 and drops m_tvalid.
// A stalled receiver holds m_tdata; one further result can wait internally,
// after which s_tready drops until the output is taken.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_median (
    input  wire                           aclk,
    input  wire                           aresetn,
    // sample[31:0]
    input  wire [swm_pkg::S_DATA_W-1:0]   s_tdata,
    // restart[0]
    input  wire                           s_tuser,
    input  wire                           s_tvalid,
    output logic                          s_tready,
    // median_x2[32:0], zero padding above
    output logic [swm_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tvalid,
    input  wire                           m_tready,
    input  wire                           cfg_wr_en,
    input  wire [swm_pkg::CFG_W-1:0]      cfg_wr_data
);

    localparam int N = swm_pkg::MAX_WINDOW;

    logic [swm_pkg::CFG_W-1:0]  win_size_reg;
    logic [swm_pkg::CNT_W-1:0]  cnt_reg;
    logic [swm_pkg::CNT_W-1:0]  cnt_next;
    logic                       pend_reg;
    logic                       pend_next;
    logic                       m_valid_reg;
    logic                       m_valid_next;
    logic signed [swm_pkg::MEDIAN_W-1:0] m_data_reg;

    logic [swm_pkg::CNT_W-1:0]  w_eff;
    logic [swm_pkg::IDX_W-1:0]  wm1;
    logic [swm_pkg::CNT_W-1:0]  cnt_after;
    logic                       xfer_in;
    logic                       out_free;
    logic                       multi_any;
    logic signed [swm_pkg::MEDIAN_W-1:0] median_x2;

    swm_pkg::cell_ctl_t ctl;
    swm_pkg::cell_t     slots [N];
    swm_pkg::cell_t     lower_s [N];
    swm_pkg::cell_t     upper_s [N];
    logic [N:0]         rem_chain;
    logic [N:0]         gt_chain;
    logic [N-1:0]       multi_vec;

    // Clamp the configured window to 1..MAX_WINDOW
    always_comb begin
        if (win_size_reg == '0) begin
            w_eff = swm_pkg::CNT_W'(1);
        end else if (swm_pkg::CNT_W'(win_size_reg) > swm_pkg::CNT_W'(N)) begin
            w_eff = swm_pkg::CNT_W'(N);
        end else begin
            w_eff = swm_pkg::CNT_W'(win_size_reg);
        end
    end
    assign wm1 = swm_pkg::IDX_W'(w_eff - swm_pkg::CNT_W'(1));

    // Handshake
    assign multi_any = |multi_vec;
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = !multi_any && (!pend_reg || out_free);
    assign xfer_in   = s_tvalid && s_tready;

    // Broadcast control
    always_comb begin
        ctl.step   = xfer_in;
        ctl.purge  = multi_any;
        ctl.clear  = xfer_in && s_tuser;
        ctl.sample = s_tdata[swm_pkg::SAMPLE_W-1:0];
        ctl.wm1    = wm1;
    end

    // Row of slots
    assign rem_chain[0] = 1'b0;
    assign gt_chain[0]  = 1'b0;

    for (genvar i = 0; i < N; i++) begin : g_cell
        if (i == 0) begin : g_lo_edge
            assign lower_s[i] = '0;
        end else begin : g_lo
            assign lower_s[i] = slots[i-1];
        end
        if (i == N - 1) begin : g_hi_edge
            assign upper_s[i] = '0;
        end else begin : g_hi
            assign upper_s[i] = slots[i+1];
        end

        swm_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .lower_i (lower_s[i]),
            .upper_i (upper_s[i]),
            .rem_in  (rem_chain[i]),
            .gt_in   (gt_chain[i]),
            .slot_o  (slots[i]),
            .rem_out (rem_chain[i+1]),
            .gt_out  (gt_chain[i+1]),
            .multi_o (multi_vec[i])
        );
    end

    // Middle slots of the full window
    swm_select u_select (
        .slots     (slots),
        .lo_idx    ({1'b0, wm1[swm_pkg::IDX_W-1:1]}),
        .hi_idx    (w_eff[swm_pkg::IDX_W:1]),
        .median_x2 (median_x2)
    );

    // Track fill level
    always_comb begin
        if (s_tuser) begin
            cnt_after = swm_pkg::CNT_W'(1);
        end else begin
            cnt_after = cnt_reg - swm_pkg::CNT_W'(rem_chain[N]) + swm_pkg::CNT_W'(1);
        end
        if (xfer_in) begin
            cnt_next = cnt_after;
        end else if (multi_any) begin
            cnt_next = cnt_reg - swm_pkg::CNT_W'(1);
        end else begin
            cnt_next = cnt_reg;
        end
    end

    // Flag a result once the window is full, hand it to the output register
    assign pend_next    = xfer_in ? (cnt_after == w_eff) : (pend_reg && !out_free);
    assign m_valid_next = (pend_reg && out_free) ? 1'b1 : (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_size_reg <= swm_pkg::CFG_W'(swm_pkg::WIN_RESET);
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                win_size_reg <= cfg_wr_data;
            end
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Load the pending result into the output register once the output is free
    always_ff @(posedge aclk) begin
        if (pend_reg && out_free) begin
            m_data_reg <= median_x2;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = swm_pkg::M_DATA_W'($unsigned(m_data_reg));

endmodule

`default_nettype wire

// File: design/swm_checker.sv
// Port-level checks for the sliding-window median, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module swm_checker (
    input wire                          aclk,
    input wire                          aresetn,
    input wire                          s_tready,
    input wire [swm_pkg::M_DATA_W-1:0]  m_tdata,
    input wire                          m_tvalid,
    input wire                          m_tready
);

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Reset drops the output
    a_rst_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Empty window after reset takes input at once
    a_rst_rdy: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

    // Zeros fill the padding of every result
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[swm_pkg::M_DATA_W-1:swm_pkg::MEDIAN_W] == '0))
        else $error("result padding not zero");

endmodule

bind sliding_window_median swm_checker u_swm_checker (.*);

`default_nettype wire
